/* hdl/pps_pkg.sv */
// Shared types, constants and the velocity decay table for the particle pool.
// No dependencies; used by pps_ctrl, pps_datapath and particle_pool_step.
package pps_pkg;

    localparam logic [23:0] DENSITY_FULL = 24'hFFFFFF;
    localparam logic [31:0] SEED_RESET   = 32'd2463534242;
    localparam logic [95:0] DECAY_RATIO  = 96'd4162825045;
    localparam int          DECAY_MAX    = 1024;
    localparam int          DECAY_IDX_W  = $clog2(DECAY_MAX);

    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_STORED = 2'd1;
    localparam logic [1:0] KIND_THIN   = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    localparam logic CFG_DENSITY = 1'b0;
    localparam logic CFG_SEED    = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [30:0] life;
        logic        [30:0] life_total;
        logic signed [31:0] gravity;
        logic        [30:0] drag;
        logic               glow;
    } entry_t;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [5:0]  slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [30:0] life_left;
        logic        [30:0] life_total;
        logic               glow;
    } result_t;

    typedef struct packed {
        logic load;
        logic tick_init;
        logic emit;
        logic rd;
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic kill;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic dead;
    } status_t;

    typedef logic [16:0] decay_tab_t [DECAY_MAX];

    // exp(-j/32) in Q1.16, built in a Q1.32 accumulator
    function automatic decay_tab_t build_decay();
        logic [95:0] acc;
        decay_tab_t  tab;
        acc = 96'd1 << 32;
        for (int j = 0; j < DECAY_MAX; j++) begin
            tab[j] = 17'((acc + 96'd32768) >> 16);
            acc    = (acc * DECAY_RATIO + (96'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam decay_tab_t DECAY_TAB = build_decay();

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] r;
        r = s;
        r = r ^ (r << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        return r;
    endfunction

endpackage

/* hdl/particle_pool_step.sv */
// Particle pool: an emit passes through the EMIT state, and its result word is registered.
// A tick runs CHK, S1 and S2 per entry, S3 to S5 also per survivor, and a final CHK at the end;
// the last report strobes in the cycle after busy drops. A new word is taken only when idle.
// Reset: live count zero, density full, generator at its seed; pool contents undefined.
// The receiver cannot stall: each result word is on the ports for one strobe cycle.
module particle_pool_step #(
    parameter int POOL_SIZE         = 64,
    parameter int DECAY_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic        [30:0] life,
    input  logic signed [31:0] gravity,
    input  logic        [30:0] drag,
    input  logic               additive,
    input  logic        [15:0] dt,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic        [31:0] cfg_data,
    output logic               strobe,
    output logic        [1:0]  kind,
    output logic        [5:0]  slot,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z,
    output logic        [30:0] life_left,
    output logic        [30:0] life_total,
    output logic               glow,
    output logic               last
);

    pps_pkg::cmd_t    cmd;
    pps_pkg::status_t status;
    pps_pkg::result_t res;

    pps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pps_datapath #(
        .POOL_SIZE         (POOL_SIZE),
        .DECAY_TABLE_DEPTH (DECAY_TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .life       (life),
        .gravity    (gravity),
        .drag       (drag),
        .additive   (additive),
        .dt         (dt),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_strobe (strobe),
        .res_last   (last),
        .res        (res)
    );

    assign cfg_ready  = !busy;
    assign kind       = res.kind;
    assign slot       = res.slot;
    assign out_pos_x  = res.pos_x;
    assign out_pos_y  = res.pos_y;
    assign out_pos_z  = res.pos_z;
    assign out_vel_x  = res.vel_x;
    assign out_vel_y  = res.vel_y;
    assign out_vel_z  = res.vel_z;
    assign life_left  = res.life_left;
    assign life_total = res.life_total;
    assign glow       = res.glow;

endmodule

/* hdl/pps_ctrl.sv */
// Sequencer for the particle pool: emit in one step, tick walks each surviving slot in six steps.
// Depends on pps_pkg (cmd_t, status_t).
module pps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  pps_pkg::status_t status,
    output pps_pkg::cmd_t    cmd,
    output logic             busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EMIT = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_S1   = 3'd3;
    localparam logic [2:0] ST_S2   = 3'd4;
    localparam logic [2:0] ST_S3   = 3'd5;
    localparam logic [2:0] ST_S4   = 3'd6;
    localparam logic [2:0] ST_S5   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (mode)
                    begin
                        cmd.tick_init = 1'b1;
                        state_next    = ST_CHK;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHK:
            begin
                if (status.done)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_S1;
                end
            end
            ST_S1:
            begin
                cmd.s1     = 1'b1;
                state_next = ST_S2;
            end
            ST_S2:
            begin
                // drop a dead slot and pull the last entry into it
                if (status.dead)
                begin
                    cmd.kill   = 1'b1;
                    state_next = ST_CHK;
                end
                else
                begin
                    cmd.s2     = 1'b1;
                    state_next = ST_S3;
                end
            end
            ST_S3:
            begin
                cmd.s3     = 1'b1;
                state_next = ST_S4;
            end
            ST_S4:
            begin
                cmd.s4     = 1'b1;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                cmd.s5     = 1'b1;
                state_next = ST_CHK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* hdl/pps_datapath.sv */
// Pool storage, generator, per-slot update arithmetic and result registers.
// Depends on pps_pkg (entry_t, result_t, cmd_t, status_t, decay table).
module pps_datapath #(
    parameter int POOL_SIZE         = 64,
    parameter int DECAY_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pps_pkg::cmd_t      cmd,
    output pps_pkg::status_t   status,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic        [30:0] life,
    input  logic signed [31:0] gravity,
    input  logic        [30:0] drag,
    input  logic               additive,
    input  logic        [15:0] dt,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic        [31:0] cfg_data,
    output logic               res_strobe,
    output logic               res_last,
    output pps_pkg::result_t   res
);

    localparam int ADDR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W  = $clog2(POOL_SIZE + 1) + 1;

    pps_pkg::entry_t mem [POOL_SIZE];

    pps_pkg::entry_t  in_reg;
    logic [15:0]      dt_reg;
    logic [23:0]      density_reg;
    logic [31:0]      rng_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] src_reg;
    logic             pend_v_reg;
    logic             strobe_reg;
    logic             last_reg;
    pps_pkg::result_t res_reg;
    pps_pkg::result_t pend_reg;

    pps_pkg::entry_t    rd_reg;
    logic signed [31:0] life_reg;
    logic signed [48:0] gdt_reg;
    logic        [46:0] ddt_reg;
    logic signed [31:0] vy_reg;
    logic        [16:0] k_reg;
    logic signed [48:0] pkx_reg, pky_reg, pkz_reg;
    logic signed [31:0] vfx_reg, vfy_reg, vfz_reg;
    logic signed [48:0] pdx_reg, pdy_reg, pdz_reg;

    logic [31:0]             rng_next;
    logic                    thin;
    logic                    full;
    logic [31:0]             idx_sum;
    logic [20:0]             idx_raw;
    logic [16:0]             k_next;
    logic signed [16:0]      dt_s;
    logic signed [17:0]      k_s;
    logic signed [31:0]      vfx_next, vfy_next, vfz_next;
    pps_pkg::entry_t         upd;
    pps_pkg::result_t        emit_res;
    pps_pkg::result_t        upd_res;
    logic                    we;
    logic [ADDR_W-1:0]       wa;
    pps_pkg::entry_t         wd;

    assign rng_next = pps_pkg::xorshift(rng_reg);
    assign thin     = (density_reg != pps_pkg::DENSITY_FULL)
                      && (rng_next[23:0] > density_reg);
    assign full     = (count_reg >= CNT_W'(POOL_SIZE));
    assign dt_s     = $signed({1'b0, dt_reg});
    // factor reaches 65536 at the table head, so keep it positive
    assign k_s      = $signed({1'b0, k_reg});

    assign status.done = (i_reg >= count_reg);
    assign status.dead = (life_reg <= 32'sd0);

    // decay index: (floor(drag*dt/65536) + 1024) >> 11, clamped to the table end
    always_comb
    begin
        idx_sum = {1'b0, ddt_reg[46:16]} + 32'd1024;
        idx_raw = idx_sum[31:11];
        if (idx_raw >= 21'(DECAY_TABLE_DEPTH))
            k_next = pps_pkg::DECAY_TAB[DECAY_TABLE_DEPTH - 1];
        else
            k_next = pps_pkg::DECAY_TAB[idx_raw[pps_pkg::DECAY_IDX_W-1:0]];
    end

    always_comb
    begin
        if (rd_reg.drag != 31'd0)
        begin
            vfx_next = pkx_reg[47:16];
            vfy_next = pky_reg[47:16];
            vfz_next = pkz_reg[47:16];
        end
        else
        begin
            vfx_next = rd_reg.vel_x;
            vfy_next = vy_reg;
            vfz_next = rd_reg.vel_z;
        end
    end

    always_comb
    begin
        upd            = rd_reg;
        upd.life       = life_reg[30:0];
        upd.vel_x      = vfx_reg;
        upd.vel_y      = vfy_reg;
        upd.vel_z      = vfz_reg;
        upd.pos_x      = pps_pkg::sat32(34'(rd_reg.pos_x) + 34'($signed(pdx_reg[48:16])));
        upd.pos_y      = pps_pkg::sat32(34'(rd_reg.pos_y) + 34'($signed(pdy_reg[48:16])));
        upd.pos_z      = pps_pkg::sat32(34'(rd_reg.pos_z) + 34'($signed(pdz_reg[48:16])));

        upd_res            = '0;
        upd_res.kind       = pps_pkg::KIND_REPORT;
        upd_res.slot       = 6'(i_reg[ADDR_W-1:0]);
        upd_res.pos_x      = upd.pos_x;
        upd_res.pos_y      = upd.pos_y;
        upd_res.pos_z      = upd.pos_z;
        upd_res.vel_x      = upd.vel_x;
        upd_res.vel_y      = upd.vel_y;
        upd_res.vel_z      = upd.vel_z;
        upd_res.life_left  = upd.life;
        upd_res.life_total = upd.life_total;
        upd_res.glow       = upd.glow;

        emit_res = '0;
        if (thin)
            emit_res.kind = pps_pkg::KIND_THIN;
        else if (full)
            emit_res.kind = pps_pkg::KIND_FULL;
        else
        begin
            emit_res.kind       = pps_pkg::KIND_STORED;
            emit_res.slot       = 6'(count_reg[ADDR_W-1:0]);
            emit_res.pos_x      = in_reg.pos_x;
            emit_res.pos_y      = in_reg.pos_y;
            emit_res.pos_z      = in_reg.pos_z;
            emit_res.vel_x      = in_reg.vel_x;
            emit_res.vel_y      = in_reg.vel_y;
            emit_res.vel_z      = in_reg.vel_z;
            emit_res.life_left  = in_reg.life;
            emit_res.life_total = in_reg.life_total;
            emit_res.glow       = in_reg.glow;
        end
    end

    always_comb
    begin
        we = 1'b0;
        wa = i_reg[ADDR_W-1:0];
        wd = upd;
        if (cmd.emit && !thin && !full)
        begin
            we = 1'b1;
            wa = count_reg[ADDR_W-1:0];
            wd = in_reg;
        end
        else if (cmd.s5)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (cmd.rd)
            rd_reg <= mem[src_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg <= pps_pkg::DENSITY_FULL;
            rng_reg     <= pps_pkg::SEED_RESET;
            count_reg   <= '0;
            i_reg       <= '0;
            src_reg     <= '0;
            pend_v_reg  <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == pps_pkg::CFG_DENSITY)
                    density_reg <= cfg_data[23:0];
                else
                    rng_reg <= cfg_data;
            end
            if (cmd.tick_init)
            begin
                i_reg      <= '0;
                src_reg    <= '0;
                pend_v_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                strobe_reg <= 1'b1;
                if (density_reg != pps_pkg::DENSITY_FULL)
                    rng_reg <= rng_next;
                if (!thin && !full)
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.kill)
            begin
                count_reg <= count_reg - 1'b1;
                src_reg   <= count_reg - 1'b1;
            end
            if (cmd.s5)
            begin
                i_reg      <= i_reg + 1'b1;
                src_reg    <= i_reg + 1'b1;
                pend_v_reg <= 1'b1;
                strobe_reg <= pend_v_reg;
            end
            if (cmd.flush)
            begin
                strobe_reg <= pend_v_reg;
                pend_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dt_reg            <= dt;
            in_reg.pos_x      <= pos_x;
            in_reg.pos_y      <= pos_y;
            in_reg.pos_z      <= pos_z;
            in_reg.vel_x      <= vel_x;
            in_reg.vel_y      <= vel_y;
            in_reg.vel_z      <= vel_z;
            in_reg.life       <= life;
            in_reg.life_total <= life;
            in_reg.gravity    <= gravity;
            in_reg.drag       <= drag;
            in_reg.glow       <= additive;
        end
        if (cmd.s1)
        begin
            life_reg <= $signed({1'b0, rd_reg.life}) - $signed({16'd0, dt_reg});
            gdt_reg  <= rd_reg.gravity * dt_s;
            ddt_reg  <= rd_reg.drag * dt_reg;
        end
        if (cmd.s2)
        begin
            vy_reg <= pps_pkg::sat32(34'(rd_reg.vel_y) - 34'($signed(gdt_reg[48:16])));
            k_reg  <= k_next;
        end
        if (cmd.s3)
        begin
            pkx_reg <= rd_reg.vel_x * k_s;
            pky_reg <= vy_reg * k_s;
            pkz_reg <= rd_reg.vel_z * k_s;
        end
        if (cmd.s4)
        begin
            vfx_reg <= vfx_next;
            vfy_reg <= vfy_next;
            vfz_reg <= vfz_next;
            pdx_reg <= vfx_next * dt_s;
            pdy_reg <= vfy_next * dt_s;
            pdz_reg <= vfz_next * dt_s;
        end
        if (cmd.emit)
        begin
            res_reg  <= emit_res;
            last_reg <= 1'b1;
        end
        // hold each report in pend_reg until the next one arrives, so the final one can carry last
        if (cmd.s5)
        begin
            res_reg  <= pend_reg;
            last_reg <= 1'b0;
            pend_reg <= upd_res;
        end
        if (cmd.flush)
        begin
            res_reg  <= pend_reg;
            last_reg <= 1'b1;
        end
    end

    assign res_strobe = strobe_reg;
    assign res_last   = last_reg;
    assign res        = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_SIZE))
        else $error("live count beyond pool size");

    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && res_reg.kind != pps_pkg::KIND_REPORT) |-> last_reg)
        else $error("emit result without last");

    a_kill_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kill |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("erase did not shrink pool");

    // after an erase the source is the entry just past the shrunk pool
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (src_reg <= count_reg))
        else $error("read beyond live entries");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for particle_pool_step: emit/tick words, density and seed registers.
// Depends on pps_pkg and the particle_pool_step RTL; holds its own pool predictor.
module tb_top;

    localparam int POOL = 64;
    localparam int TAB_DEPTH = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic        mode;
        logic [31:0] px, py, pz, vx, vy, vz;
        logic [30:0] life;
        logic [31:0] grav;
        logic [30:0] drag;
        logic        add;
        logic [15:0] dt;
    } word_t;

    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  slot;
        logic [31:0] px, py, pz, vx, vy, vz;
        logic [30:0] life_left, life_total;
        logic        glow, last;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic mode = 1'b0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic [30:0] life = '0;
    logic signed [31:0] gravity = '0;
    logic [30:0] drag = '0;
    logic additive = 1'b0;
    logic [15:0] dt = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic strobe;
    logic [1:0] kind;
    logic [5:0] slot;
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;
    logic [30:0] life_left, life_total;
    logic glow, last;

    particle_pool_step DUT (.*);

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [23:0] density_q;
    logic [31:0] rng_q;
    int          live_q;
    longint      p_x[POOL], p_y[POOL], p_z[POOL], v_x[POOL], v_y[POOL], v_z[POOL];
    longint      life_q[POOL], grav_q[POOL];
    logic [30:0] total_q[POOL], drag_q[POOL];
    logic        glow_q[POOL];
    longint      decay_q[TAB_DEPTH];

    word_t   pending_words[$];
    report_t expected_reports[$];
    int      errors = 0;
    int      idle_pct = 0;
    bit      hold_off = 0;

    function automatic longint fdiv16(longint p);
        return p >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic report_t slot_report(logic [1:0] k, int i);
        report_t r;
        r.kind = k; r.slot = i[5:0];
        r.px = p_x[i][31:0]; r.py = p_y[i][31:0]; r.pz = p_z[i][31:0];
        r.vx = v_x[i][31:0]; r.vy = v_y[i][31:0]; r.vz = v_z[i][31:0];
        r.life_left = life_q[i][30:0]; r.life_total = total_q[i]; r.glow = glow_q[i];
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_pool(word_t w);
        report_t r;
        logic [31:0] s;
        int i, n;
        longint e, idx, k, d;
        if (w.mode == 1'b0) begin
            r = '{default: '0};
            r.last = 1'b1;
            if (density_q != pps_pkg::DENSITY_FULL) begin
                s = rng_q;
                s = s ^ (s << 13); s = s ^ (s >> 17); s = s ^ (s << 5);
                rng_q = s;
                if (s[23:0] > density_q) begin
                    r.kind = pps_pkg::KIND_THIN; expected_reports.push_back(r); return;
                end
            end
            if (live_q >= POOL) begin
                r.kind = pps_pkg::KIND_FULL; expected_reports.push_back(r); return;
            end
            i = live_q;
            p_x[i] = longint'(signed'(w.px)); p_y[i] = longint'(signed'(w.py));
            p_z[i] = longint'(signed'(w.pz)); v_x[i] = longint'(signed'(w.vx));
            v_y[i] = longint'(signed'(w.vy)); v_z[i] = longint'(signed'(w.vz));
            life_q[i] = longint'(w.life); total_q[i] = w.life;
            grav_q[i] = longint'(signed'(w.grav)); drag_q[i] = w.drag; glow_q[i] = w.add;
            live_q++;
            r = slot_report(pps_pkg::KIND_STORED, i);
            r.last = 1'b1;
            expected_reports.push_back(r);
        end else begin
            d = longint'(w.dt);
            i = 0; n = 0;
            while (i < live_q) begin
                life_q[i] -= d;
                if (life_q[i] <= 0) begin
                    live_q--;
                    p_x[i] = p_x[live_q]; p_y[i] = p_y[live_q]; p_z[i] = p_z[live_q];
                    v_x[i] = v_x[live_q]; v_y[i] = v_y[live_q]; v_z[i] = v_z[live_q];
                    life_q[i] = life_q[live_q]; total_q[i] = total_q[live_q];
                    grav_q[i] = grav_q[live_q]; drag_q[i] = drag_q[live_q];
                    glow_q[i] = glow_q[live_q];
                    continue;
                end
                v_y[i] = clamp32(v_y[i] - fdiv16(grav_q[i] * d));
                if (drag_q[i] != 0) begin
                    e = (longint'(drag_q[i]) * d) >> 16;
                    idx = (e + 1024) >> 11;
                    if (idx >= TAB_DEPTH) idx = TAB_DEPTH - 1;
                    k = decay_q[idx];
                    v_x[i] = fdiv16(v_x[i] * k);
                    v_y[i] = fdiv16(v_y[i] * k);
                    v_z[i] = fdiv16(v_z[i] * k);
                end
                p_x[i] = clamp32(p_x[i] + fdiv16(v_x[i] * d));
                p_y[i] = clamp32(p_y[i] + fdiv16(v_y[i] * d));
                p_z[i] = clamp32(p_z[i] + fdiv16(v_z[i] * d));
                expected_reports.push_back(slot_report(pps_pkg::KIND_REPORT, i));
                n++; i++;
            end
            if (n > 0) expected_reports[$].last = 1'b1;
        end
    endtask

    // driver: predict at the accepting edge, so results compare in order
    always @(posedge clk) begin
        if (start && !busy && rst_n) begin
            predict_pool(pending_words.pop_front());
        end
        if (rst_n && !hold_off && pending_words.size() > 0 && !(start && !busy
                && pending_words.size() == 1) && $urandom_range(99) >= idle_pct) begin
            word_t w;
            w = (start && !busy) ? pending_words[0] : pending_words[0];
            start <= 1'b1;
            mode <= w.mode; pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
            vel_x <= w.vx; vel_y <= w.vy; vel_z <= w.vz; life <= w.life;
            gravity <= w.grav; drag <= w.drag; additive <= w.add; dt <= w.dt;
        end else if (!(start && busy)) begin
            start <= 1'b0;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch expected %h actual %h", $realtime, name, want, got);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk) begin
        report_t x;
        if (rst_n && strobe) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result kind %0d slot %0d", $realtime, kind, slot);
                errors++;
            end else begin
                x = expected_reports.pop_front();
                check_field("kind", x.kind, kind);
                check_field("slot", x.slot, slot);
                check_field("pos_x", x.px, out_pos_x);
                check_field("pos_y", x.py, out_pos_y);
                check_field("pos_z", x.pz, out_pos_z);
                check_field("vel_x", x.vx, out_vel_x);
                check_field("vel_y", x.vy, out_vel_y);
                check_field("vel_z", x.vz, out_vel_z);
                check_field("life_left", x.life_left, life_left);
                check_field("life_total", x.life_total, life_total);
                check_field("glow", x.glow, glow);
                check_field("last", x.last, last);
            end
        end
    end

    // watchdog: cycles with no word accepted either way
    int quiet = 0;
    always @(posedge clk) begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_edge32();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t make_emit(logic [31:0] lf);
        word_t w;
        w.mode = 1'b0;
        w.px = rnd_edge32(); w.py = rnd_edge32(); w.pz = rnd_edge32();
        w.vx = rnd_edge32(); w.vy = rnd_edge32(); w.vz = rnd_edge32();
        w.life = lf[30:0]; w.grav = rnd_edge32();
        w.drag = ($urandom_range(3) == 0) ? 31'd0 : 31'($urandom);
        if ($urandom_range(3) == 0) w.drag = 31'($urandom_range(200000));
        w.add = 1'($urandom_range(1));
        w.dt = 16'($urandom);
        return w;
    endfunction

    function automatic word_t make_tick(logic [15:0] step);
        word_t w;
        w = make_emit($urandom);
        w.mode = 1'b1; w.dt = step;
        return w;
    endfunction

    task automatic drain();
        while (pending_words.size() > 0 || start || expected_reports.size() > 0)
            @(posedge clk);
        repeat (2 + 6 * POOL + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == pps_pkg::CFG_DENSITY) density_q = val[23:0];
        else rng_q = val;
    endtask

    initial begin
        word_t w;
        logic [31:0] acc;
        longint unsigned a;
        a = 64'd1 << 32;
        for (int j = 0; j < TAB_DEPTH; j++) begin
            decay_q[j] = longint'((a + 32768) >> 16);
            a = (a * 64'd4162825045 + (64'd1 << 31)) >> 32;
        end
        density_q = pps_pkg::DENSITY_FULL; rng_q = pps_pkg::SEED_RESET; live_q = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero life, empty tick, dt extremes, pool fill
        pending_words.push_back(make_tick(16'hFFFF));
        w = make_emit(0); pending_words.push_back(w);
        pending_words.push_back(make_tick(16'd0));
        w = make_emit(31'h7FFFFFFF); w.px = 32'h7FFFFFFF; w.vx = 32'h7FFFFFFF;
        w.vy = 32'h80000000; w.grav = 32'h7FFFFFFF; w.drag = 31'h7FFFFFFF; w.add = 1;
        pending_words.push_back(w);
        w = make_emit(31'h7FFFFFFF); w.px = 32'h80000000; w.vx = 32'h80000000;
        w.grav = 32'h80000000; w.drag = 31'd0; w.add = 0;
        pending_words.push_back(w);
        pending_words.push_back(make_tick(16'hFFFF));
        pending_words.push_back(make_tick(16'd1));
        drain();

        // fill the pool past full
        for (int j = 0; j < 70; j++) pending_words.push_back(make_emit($urandom));
        pending_words.push_back(make_tick(16'($urandom)));
        drain();
        // age the pool and let all results drain, then hold back a queued emit before releasing it
        for (int j = 0; j < 3; j++) pending_words.push_back(make_tick(16'hFFFF));
        drain();
        hold_off = 1;
        pending_words.push_back(make_emit($urandom));
        repeat (20) @(posedge clk);
        hold_off = 0;
        drain();

        write_reg(pps_pkg::CFG_DENSITY, 32'h0);
        write_reg(pps_pkg::CFG_SEED, 32'hFFFFFFFF);
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 0) ? 0 : (phase == 3) ? 14 : 57;
            case (phase)
                1: write_reg(pps_pkg::CFG_DENSITY, 32'h800000);
                2: write_reg(pps_pkg::CFG_SEED, 32'd1);
                3: begin
                    write_reg(pps_pkg::CFG_DENSITY, pps_pkg::DENSITY_FULL);
                    write_reg(pps_pkg::CFG_SEED, 32'd0);
                    write_reg(pps_pkg::CFG_DENSITY, 32'h0000FF);
                end
                default: ;
            endcase
            for (int j = 0; j < 7; j++) begin
                acc = $urandom;
                if ($urandom_range(2) == 0)
                    pending_words.push_back(make_tick(($urandom_range(1) == 0) ?
                        16'($urandom_range(2000)) : 16'($urandom)));
                else
                    pending_words.push_back(make_emit(($urandom_range(1) == 0) ?
                        acc[30:0] : 31'($urandom_range(300000))));
            end
            drain();
        end
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
